// File: hdl/base64_decoder_assert.svh
// Assertion helpers, clocked on aclk, off while aresetn is low.
`ifndef BASE64_DECODER_ASSERT_SVH
`define BASE64_DECODER_ASSERT_SVH

// same-cycle implication
`define B64D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define B64D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/b64d_pkg.sv
package b64d_pkg;

    localparam int unsigned GROUP_BITS = 24;

    // one queued job: up to three bytes of a group, or a lone end marker
    typedef struct packed {
        logic [GROUP_BITS-1:0] group;
        logic [1:0]            nbytes; // 0: single beat without a byte
        logic                  fin;
        logic                  err;
    } cmd_t;

endpackage

// File: hdl/b64d_front.sv
module b64d_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_in_char,
    input  logic            s_end_of_message,
    input  logic            q_full,
    output logic            q_push,
    output b64d_pkg::cmd_t  q_cmd
);
    import b64d_pkg::*;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    // {skip, value}
    function automatic logic [6:0] decode(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        priority if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d = c - CHAR_UPPER_A;
            return {1'b0, d[5:0]};
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d = c - CHAR_LOWER_A + 8'd26;
            return {1'b0, d[5:0]};
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO + 8'd52;
            return {1'b0, d[5:0]};
        end else if (c == CHAR_PLUS) begin
            return {1'b0, 6'd62};
        end else if (c == CHAR_SLASH) begin
            return {1'b0, 6'd63};
        end else if (c == CHAR_PAD) begin
            return {1'b0, 6'd0};
        end else begin
            return {1'b1, 6'd0};
        end
    endfunction

    logic [17:0] partial_reg, partial_next;
    logic [1:0]  pos_reg, pos_next;
    logic        third_pad_reg, third_pad_next;
    logic [23:0] held_reg, held_next;
    logic        held_valid_reg, held_valid_next;
    logic [1:0]  held_pad_reg, held_pad_next;

    logic [6:0]  dec;
    logic        char_ok;
    logic        is_pad;
    logic        flush;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign dec     = decode(s_in_char);
    assign char_ok = !dec[6];
    assign is_pad  = (s_in_char == CHAR_PAD);
    assign flush   = char_ok && (pos_reg == 2'd0) && held_valid_reg;

    always_comb begin
        partial_next    = partial_reg;
        pos_next        = pos_reg;
        third_pad_next  = third_pad_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        held_pad_next   = held_pad_reg;

        q_cmd.group  = held_reg;
        q_cmd.nbytes = 2'd3;
        q_cmd.fin    = 1'b0;
        q_cmd.err    = 1'b0;
        q_push       = 1'b0;

        if (char_ok) begin
            if (flush) begin
                q_push          = 1'b1;
                held_valid_next = 1'b0;
            end
            if (pos_reg != 2'd3) begin
                partial_next = {partial_reg[11:0], dec[5:0]};
                if (pos_reg == 2'd2) begin
                    third_pad_next = is_pad;
                end
                pos_next = pos_reg + 2'd1;
            end else begin
                held_next       = {partial_reg, dec[5:0]};
                held_valid_next = 1'b1;
                held_pad_next   = {third_pad_reg, is_pad};
                partial_next    = '0;
                third_pad_next  = 1'b0;
                pos_next        = 2'd0;
            end
        end

        if (s_end_of_message) begin
            q_push = 1'b1;
            if (pos_next != 2'd0) begin
                q_cmd.fin = 1'b1;
                q_cmd.err = 1'b1;
                if (!flush) begin
                    q_cmd.nbytes = 2'd0;
                end
            end else if (held_valid_next) begin
                q_cmd.group = held_next;
                q_cmd.fin   = 1'b1;
                priority if (held_pad_next[1]) begin
                    q_cmd.nbytes = 2'd1;
                end else if (held_pad_next[0]) begin
                    q_cmd.nbytes = 2'd2;
                end else begin
                    q_cmd.nbytes = 2'd3;
                end
            end else begin
                q_cmd.nbytes = 2'd0;
                q_cmd.fin    = 1'b1;
            end
            partial_next    = '0;
            pos_next        = 2'd0;
            third_pad_next  = 1'b0;
            held_next       = '0;
            held_valid_next = 1'b0;
            held_pad_next   = 2'd0;
        end

        if (!accept) begin
            q_push = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg    <= '0;
            pos_reg        <= 2'd0;
            third_pad_reg  <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            held_pad_reg   <= 2'd0;
        end else if (accept) begin
            partial_reg    <= partial_next;
            pos_reg        <= pos_next;
            third_pad_reg  <= third_pad_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            held_pad_reg   <= held_pad_next;
        end
    end

endmodule

// File: hdl/b64d_fifo.sv
`include "base64_decoder_assert.svh"

module b64d_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  b64d_pkg::cmd_t  din,
    output logic            full,
    input  logic            pop,
    output b64d_pkg::cmd_t  dout,
    output logic            empty
);
    import b64d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_reg];

    assign wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
    assign rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_next;
            end
            if (pop) begin
                rd_reg <= rd_next;
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `B64D_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `B64D_ASSERT_NOW(a_empty_ptrs, empty, wr_reg == rd_reg)
    `B64D_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

// File: hdl/b64d_back.sv
`include "base64_decoder_assert.svh"

module b64d_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  b64d_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_byte_valid,
    output logic            m_final_result,
    output logic            m_length_error
);
    import b64d_pkg::*;

    cmd_t       cmd_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    logic       last;
    logic       take;
    logic [7:0] sel;

    assign last  = (cmd_reg.nbytes == 2'd0) || (idx_reg == cmd_reg.nbytes - 2'd1);
    assign take  = busy_reg && m_ready;
    assign q_pop = !q_empty && (!busy_reg || (take && last));

    always_comb begin
        unique case (idx_reg)
            2'd0:    sel = cmd_reg.group[23:16];
            2'd1:    sel = cmd_reg.group[15:8];
            default: sel = cmd_reg.group[7:0];
        endcase
    end

    assign m_valid        = busy_reg;
    assign m_byte_valid   = (cmd_reg.nbytes != 2'd0);
    assign m_out_byte     = m_byte_valid ? sel : 8'h00;
    assign m_final_result = cmd_reg.fin && last;
    assign m_length_error = cmd_reg.err && last;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end else if (take) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    `B64D_ASSERT_NOW(a_err_on_final, m_valid && m_length_error, m_final_result)
    `B64D_ASSERT_NOW(a_bare_is_final, m_valid && !m_byte_valid, m_final_result)

endmodule

// File: hdl/base64_decoder.sv
// Base64 decoder: one character beat accepted per cycle while the job queue has room.
// A beat that yields output goes into a queue entry, then the back-end command register.
// Throughput: results leave the back end at one beat per cycle while m_ready is high; a full
// group gives three result beats, the queue (DEPTH jobs) absorbs bursts before input stalls.
// Reset: synchronous, active-low aresetn clears decode state, queue and output stage.
module base64_decoder #(
    parameter int unsigned DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_final_result,
    output logic       m_length_error
);
    import b64d_pkg::*;

    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    b64d_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_char        (s_in_char),
        .s_end_of_message (s_end_of_message),
        .q_full           (full),
        .q_push           (push),
        .q_cmd            (push_cmd)
    );

    b64d_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_cmd),
        .full    (full),
        .pop     (pop),
        .dout    (pop_cmd),
        .empty   (empty)
    );

    b64d_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (empty),
        .q_cmd          (pop_cmd),
        .q_pop          (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_final_result (m_final_result),
        .m_length_error (m_length_error)
    );

endmodule
